FILE: hw/rtl/gssw_pkg.sv
// Package: shared types, codes and defaults of the grouped stream stall watchdog.
`default_nettype none

package gssw_pkg;

    localparam int unsigned STREAM_SLOTS_DEF = 16;
    localparam int unsigned GROUP_COUNT_DEF  = 8;
    localparam int unsigned TIME_BITS_DEF    = 40;
    localparam logic [31:0] TIMEOUT_RESET    = 32'd5000;

    typedef enum logic [1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_ACTIVITY   = 2'd2,
        REQ_SCAN       = 2'd3
    } t_req_type;

    typedef enum logic {
        EVT_STREAM = 1'b0,
        EVT_GROUP  = 1'b1
    } t_evt_kind;

    typedef struct packed {
        t_req_type   req_type;
        logic [3:0]  stream_slot;
        logic [2:0]  group_id;
        logic [39:0] now_ms;
    } t_wd_req;

    typedef struct packed {
        t_evt_kind   evt_kind;
        logic [3:0]  stall_slot;
        logic [2:0]  stall_group;
        logic [39:0] idle_ms;
        logic        last_event;
    } t_wd_evt;

endpackage

`default_nettype wire

FILE: hw/rtl/gssw_slot_mem.sv
// Slot table memory: group and last-activity time per slot, registered read.
`default_nettype none

module gssw_slot_mem #(
    parameter int unsigned DEPTH  = gssw_pkg::STREAM_SLOTS_DEF,
    parameter int unsigned DATA_W = gssw_pkg::TIME_BITS_DEF + 3,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/grouped_stream_stall_watchdog.sv
// Top level: grouped stream stall watchdog with slot table memory and scan sequencer.
// Register and unregister items are done in the idle state; activity on a registered slot is a RMW through S_ACT.
// A scan reads one slot memory entry per cycle, then checks one
// group per cycle. Events leave one per cycle; the last one shows in the first cycle busy is low.
// The receiver cannot stall: each event is shown for one cycle on o_result_strobe.
// Synchronous reset clears slot valid bits, fired latches and sets the timeout to 5000.
`default_nettype none

module grouped_stream_stall_watchdog #(
    parameter int unsigned STREAM_SLOTS = gssw_pkg::STREAM_SLOTS_DEF,
    parameter int unsigned GROUP_COUNT  = gssw_pkg::GROUP_COUNT_DEF,
    parameter int unsigned TIME_BITS    = gssw_pkg::TIME_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire gssw_pkg::t_wd_req i_req,
    input  wire logic             i_cfg_we,
    input  wire logic [31:0]      i_cfg_wdata,
    output logic                  o_result_strobe,
    output gssw_pkg::t_wd_evt     o_evt
);

    import gssw_pkg::*;

    localparam int unsigned SLOT_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam int unsigned GRP_W  = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int unsigned ENT_W  = GRP_W + TIME_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ACT   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_GRP   = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [31:0]             r_timeout;
    logic [STREAM_SLOTS-1:0] r_valid;
    logic [GROUP_COUNT-1:0]  r_fired;
    logic [GROUP_COUNT-1:0]  r_member;
    logic [GROUP_COUNT-1:0]  r_all;
    logic [TIME_BITS-1:0]    r_now;
    logic [SLOT_W-1:0]       r_slot;
    logic [SLOT_W-1:0]       r_idx;
    logic [GRP_W-1:0]        r_g;
    logic                    r_rd_v;
    logic [SLOT_W-1:0]       r_rd_slot;
    logic                    r_pend_v;
    t_wd_evt                 r_pend;
    logic                    r_out_v;
    t_wd_evt                 r_out;

    logic                 accept;
    logic                 slot_ok;
    logic                 grp_ok;
    logic [SLOT_W-1:0]    in_slot;
    logic [GRP_W-1:0]     in_grp;
    logic [TIME_BITS-1:0] in_now;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    logic [ENT_W-1:0]     mem_wdata;
    logic                 mem_re;
    logic [SLOT_W-1:0]    mem_raddr;
    logic [ENT_W-1:0]     mem_rdata;
    logic [TIME_BITS-1:0] rd_time;
    logic [GRP_W-1:0]     rd_grp;
    logic [TIME_BITS-1:0] elapsed;
    logic                 stalled;
    logic                 grp_fire;
    logic                 prod_v;
    t_wd_evt              prod_evt;
    t_wd_evt              flush_evt;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign slot_ok = (32'(i_req.stream_slot) < STREAM_SLOTS);
    assign grp_ok  = (32'(i_req.group_id) < GROUP_COUNT);
    assign in_slot = SLOT_W'(i_req.stream_slot);
    assign in_grp  = GRP_W'(i_req.group_id);
    assign in_now  = TIME_BITS'(i_req.now_ms);

    assign rd_time = mem_rdata[TIME_BITS-1:0];
    assign rd_grp  = mem_rdata[TIME_BITS +: GRP_W];
    assign elapsed = r_now - rd_time;
    assign stalled = (64'(elapsed) > 64'(r_timeout));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = in_slot;
        mem_wdata = {in_grp, in_now};
        mem_re    = 1'b0;
        mem_raddr = in_slot;
        if (r_state == S_ACT) begin
            mem_we    = 1'b1;
            mem_waddr = r_slot;
            mem_wdata = {rd_grp, r_now};
        end else if (accept && i_req.req_type == REQ_REGISTER && slot_ok && grp_ok) begin
            mem_we = 1'b1;
        end
        if (r_state == S_SCAN) begin
            mem_re    = 1'b1;
            mem_raddr = r_idx;
        end else if (accept && i_req.req_type == REQ_ACTIVITY) begin
            mem_re = 1'b1;
        end
    end

    gssw_slot_mem #(
        .DEPTH  (STREAM_SLOTS),
        .DATA_W (ENT_W)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign grp_fire = (r_state == S_GRP) && r_member[r_g] && r_all[r_g] && !r_fired[r_g];

    always_comb begin
        prod_v   = 1'b0;
        prod_evt = '{evt_kind: EVT_STREAM, stall_slot: 4'(r_rd_slot),
                     stall_group: 3'(rd_grp), idle_ms: 40'(elapsed), last_event: 1'b0};
        if (r_rd_v && stalled) begin
            prod_v = 1'b1;
        end else if (grp_fire) begin
            prod_v   = 1'b1;
            prod_evt = '{evt_kind: EVT_GROUP, stall_slot: 4'd0,
                         stall_group: 3'(r_g), idle_ms: 40'd0, last_event: 1'b0};
        end
    end

    always_comb begin
        flush_evt            = r_pend;
        flush_evt.last_event = 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_req.req_type == REQ_SCAN) begin
                    n_state = S_SCAN;
                end else if (accept && i_req.req_type == REQ_ACTIVITY && slot_ok
                             && r_valid[in_slot]) begin
                    n_state = S_ACT;
                end
            end
            S_ACT:   n_state = S_IDLE;
            S_SCAN: begin
                if (r_idx == SLOT_W'(STREAM_SLOTS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_GRP;
            S_GRP: begin
                if (r_g == GRP_W'(GROUP_COUNT - 1)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= TIMEOUT_RESET;
            r_valid   <= '0;
            r_fired   <= '0;
            r_rd_v    <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (accept && slot_ok) begin
                if (i_req.req_type == REQ_REGISTER && grp_ok) begin
                    r_valid[in_slot] <= 1'b1;
                end else if (i_req.req_type == REQ_UNREGISTER) begin
                    r_valid[in_slot] <= 1'b0;
                end
            end
            if (r_state == S_ACT) begin
                r_fired[rd_grp] <= 1'b0;
            end
            if (grp_fire) begin
                r_fired[r_g] <= 1'b1;
            end
            r_rd_v  <= (r_state == S_SCAN) && r_valid[r_idx];
            r_out_v <= 1'b0;
            if (prod_v) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out_v <= 1'b1;
                end
            end else if (r_state == S_FLUSH && r_pend_v) begin
                r_pend_v <= 1'b0;
                r_out_v  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now  <= in_now;
            r_slot <= in_slot;
        end
        if (accept && i_req.req_type == REQ_SCAN) begin
            r_member <= '0;
            r_all    <= '1;
            r_idx    <= '0;
        end else if (r_state == S_SCAN) begin
            r_idx <= r_idx + SLOT_W'(1);
        end
        r_rd_slot <= r_idx;
        if (r_rd_v) begin
            r_member[rd_grp] <= 1'b1;
            if (!stalled) begin
                r_all[rd_grp] <= 1'b0;
            end
        end
        if (r_state == S_DRAIN) begin
            r_g <= '0;
        end else if (r_state == S_GRP) begin
            r_g <= r_g + GRP_W'(1);
        end
        if (prod_v) begin
            r_pend <= prod_evt;
            r_out  <= r_pend;
        end else if (r_state == S_FLUSH) begin
            r_out <= flush_evt;
        end
    end

    assign o_result_strobe = r_out_v;
    assign o_evt           = r_out;

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> ($past(r_state) == S_SCAN || $past(r_state) == S_DRAIN
                             || $past(r_state) == S_GRP || $past(r_state) == S_FLUSH))
        else $error("event strobe without a scan in progress");

    a_quiet_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type != REQ_SCAN) |=> !o_result_strobe)
        else $error("event after a non-scan item");

    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_evt.last_event) |-> (r_state == S_IDLE && !r_pend_v))
        else $error("last event while scan still running");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> !r_pend_v)
        else $error("pending event left after scan");

endmodule

`default_nettype wire
